// ----- rtl/gmm_diagonal_posterior_top_defines.svh -----
// Assertion macros for the diagonal Gaussian mixture posterior block.
// Used by the top level only; needs a clk and rst in scope.
`ifndef GMM_DIAGONAL_POSTERIOR_TOP_DEFINES_SVH
`define GMM_DIAGONAL_POSTERIOR_TOP_DEFINES_SVH

// Implication in the same cycle.
`define GMMDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define GMMDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/gmmdp_pkg.sv -----
// Package for the diagonal Gaussian mixture posterior block: sizes,
// fixed-point constants and the log and exp tables. No dependencies.
package gmmdp_pkg;

  localparam int NUM_COMPONENTS = 16;
  localparam int NUM_DIMS       = 64;
  localparam int COMP_W         = $clog2(NUM_COMPONENTS);
  localparam int DIM_W          = $clog2(NUM_DIMS);
  localparam int ADDR_W         = $clog2(NUM_COMPONENTS * NUM_DIMS);

  localparam int DIVIDEND_W = 41;
  localparam int DIVISOR_W  = 17;

  localparam logic [16:0] LN2_Q16     = 17'd45426;
  localparam logic [16:0] LN2PI_Q16   = 17'd120447;
  localparam logic [16:0] INV_LN2_Q16 = 17'd94548;

  // Word kinds on the slave side and register indexes.
  localparam logic KIND_LOAD      = 1'b0;
  localparam logic KIND_ELEMENT   = 1'b1;
  localparam logic CFG_COMPONENTS = 1'b0;
  localparam logic CFG_DIMS       = 1'b1;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_resp_t;

  function automatic logic [15:0] ln_tab(input logic [3:0] k);
    logic [15:0] v;
    case (k)
      4'd0:  v = 16'd0;
      4'd1:  v = 16'd3973;
      4'd2:  v = 16'd7719;
      4'd3:  v = 16'd11262;
      4'd4:  v = 16'd14624;
      4'd5:  v = 16'd17821;
      4'd6:  v = 16'd20870;
      4'd7:  v = 16'd23783;
      4'd8:  v = 16'd26573;
      4'd9:  v = 16'd29248;
      4'd10: v = 16'd31818;
      4'd11: v = 16'd34292;
      4'd12: v = 16'd36675;
      4'd13: v = 16'd38975;
      4'd14: v = 16'd41196;
      4'd15: v = 16'd43345;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] exp_tab(input logic [3:0] k);
    logic [16:0] v;
    case (k)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd62757;
      4'd2:  v = 17'd60097;
      4'd3:  v = 17'd57549;
      4'd4:  v = 17'd55109;
      4'd5:  v = 17'd52773;
      4'd6:  v = 17'd50535;
      4'd7:  v = 17'd48393;
      4'd8:  v = 17'd46341;
      4'd9:  v = 17'd44376;
      4'd10: v = 17'd42495;
      4'd11: v = 17'd40693;
      4'd12: v = 17'd38968;
      4'd13: v = 17'd37316;
      4'd14: v = 17'd35734;
      4'd15: v = 17'd34219;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // ln(x / 2^fb) in Q16.16 for x >= 1: octave from the top set bit,
  // fraction from the four bits below it.
  function automatic logic signed [31:0] ln_q(input logic [20:0] x, input logic [4:0] fb);
    logic [4:0]         p;
    logic [20:0]        sh;
    logic [3:0]         k;
    logic signed [6:0]  oct;
    logic signed [31:0] res;
    p = 5'd0;
    for (int i = 0; i < 21; i++) begin
      if (x[i]) p = 5'(i);
    end
    if (p >= 5'd4) sh = x >> (p - 5'd4);
    else sh = x << (5'd4 - p);
    k   = sh[3:0];
    oct = $signed({2'b00, p}) - $signed({2'b00, fb});
    res = 32'(oct * $signed({15'd0, LN2_Q16})) + $signed({16'd0, ln_tab(k)});
    return res;
  endfunction

endpackage

// ----- rtl/gmmdp_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on gmmdp_pkg for widths and the response struct.
module gmmdp_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [gmmdp_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [gmmdp_pkg::DIVISOR_W-1:0]  divisor,
  output gmmdp_pkg::div_resp_t             resp
);

  localparam int CNT_W = $clog2(gmmdp_pkg::DIVIDEND_W + 1);

  logic                             busy;
  logic [CNT_W-1:0]                 count;
  logic [gmmdp_pkg::DIVIDEND_W-1:0] num;
  logic [gmmdp_pkg::DIVIDEND_W-1:0] quo;
  logic [gmmdp_pkg::DIVISOR_W:0]    rem;
  logic [gmmdp_pkg::DIVISOR_W-1:0]  den;
  logic                             done;
  logic [gmmdp_pkg::DIVISOR_W:0]    trial;
  logic                             fits;

  assign trial = {rem[gmmdp_pkg::DIVISOR_W-1:0], num[gmmdp_pkg::DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(gmmdp_pkg::DIVIDEND_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      num <= {num[gmmdp_pkg::DIVIDEND_W-2:0], 1'b0};
      rem <= fits ? (trial - {1'b0, den}) : trial;
      quo <= {quo[gmmdp_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  assign resp.done     = done;
  assign resp.quotient = quo;

endmodule

// ----- rtl/gmm_diagonal_posterior_top.sv -----
// Diagonal-covariance Gaussian mixture posterior, top level.
// Depends on gmmdp_pkg, gmmdp_div and gmm_diagonal_posterior_top_defines.svh.
//
// Words on the slave side either load one mean and variance entry (tuser 0) or
// carry one feature element of a sample (tuser 1); tlast marks the last element.
// Loads and elements are taken while the block is idle. On the last element the
// block stops taking words and scores the sample: for each active component it
// walks the active dimensions, reading mean and variance from the model memories
// and the element from the sample memory, and divides 256 times the squared
// distance by the variance plus one in a serial divider that yields one quotient
// bit per cycle. Each dimension of each component is read, multiplied, put
// through 41 divider steps and accumulated. After the scores it sums the
// exponentials, takes the log of the sum and then emits the posterior words,
// each waiting for the output register to free.
// The divider loop sets the rate. Posteriors leave in component order, tlast on
// the final one; the block takes new words again as soon as that last word sits
// in the output register. Configuration writes take effect on the next sample.
`include "gmm_diagonal_posterior_top_defines.svh"

module gmm_diagonal_posterior_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // component[3:0], position[9:4], mean_value[25:10], variance_value[41:26],
  // sample_value[57:42], zero fill above
  input  logic [63:0] s_tdata,
  // kind[0]
  input  logic        s_tuser,
  // last_element
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_component[3:0], posterior[19:4], zero fill above
  output logic [23:0] m_tdata,
  // last_result
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int CW = gmmdp_pkg::COMP_W;
  localparam int DW = gmmdp_pkg::DIM_W;
  localparam int AW = gmmdp_pkg::ADDR_W;

  localparam logic [16:0] INV_MUL = gmmdp_pkg::INV_LN2_Q16;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_RD    = 11'b00000000010,
    ST_MUL   = 11'b00000000100,
    ST_DIV   = 11'b00000001000,
    ST_WAIT  = 11'b00000010000,
    ST_SCORE = 11'b00000100000,
    ST_ERD   = 11'b00001000000,
    ST_EMUL  = 11'b00010000000,
    ST_ELUT  = 11'b00100000000,
    ST_LN    = 11'b01000000000,
    ST_EMIT  = 11'b10000000000
  } state_t;

  state_t state;

  // Input word fields.
  logic [3:0]  in_component;
  logic [5:0]  in_position;
  logic [15:0] in_mean;
  logic [15:0] in_variance;
  logic [15:0] in_sample;
  assign in_component = s_tdata[3:0];
  assign in_position  = s_tdata[9:4];
  assign in_mean      = s_tdata[25:10];
  assign in_variance  = s_tdata[41:26];
  assign in_sample    = s_tdata[57:42];

  logic s_acc;
  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  logic [4:0] active_components;
  logic [6:0] active_dims;
  always_ff @(posedge clk) begin
    if (rst) begin
      active_components <= 5'd16;
      active_dims       <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gmmdp_pkg::CFG_COMPONENTS: active_components <= cfg_data[4:0];
        gmmdp_pkg::CFG_DIMS:       active_dims       <= cfg_data;
        default:                   active_dims       <= active_dims;
      endcase
    end
  end

  // Clamped run counts.
  logic [CW:0] kc_clamp;
  logic [DW:0] kd_clamp;
  always_comb begin
    kc_clamp = (active_components > 5'(gmmdp_pkg::NUM_COMPONENTS))
               ? (CW+1)'(gmmdp_pkg::NUM_COMPONENTS) : (CW+1)'(active_components);
    if (kc_clamp == '0) kc_clamp = (CW+1)'(1);
    kd_clamp = (active_dims > 7'(gmmdp_pkg::NUM_DIMS))
               ? (DW+1)'(gmmdp_pkg::NUM_DIMS) : (DW+1)'(active_dims);
    if (kd_clamp == '0) kd_clamp = (DW+1)'(1);
  end

  // Memories.
  logic [15:0] mean_mem   [gmmdp_pkg::NUM_COMPONENTS*gmmdp_pkg::NUM_DIMS];
  logic [15:0] var_mem    [gmmdp_pkg::NUM_COMPONENTS*gmmdp_pkg::NUM_DIMS];
  logic [15:0] sample_mem [gmmdp_pkg::NUM_DIMS];
  logic [31:0] score_mem  [gmmdp_pkg::NUM_COMPONENTS];

  logic [CW-1:0] comp_idx;
  logic [DW-1:0] dim_idx;
  logic [CW:0]   kc_run;
  logic [DW:0]   kd_run;
  logic          post_phase;

  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          load_ok;
  assign wr_addr = AW'(in_component) * AW'(gmmdp_pkg::NUM_DIMS) + AW'(in_position);
  assign rd_addr = AW'(comp_idx) * AW'(gmmdp_pkg::NUM_DIMS) + AW'(dim_idx);
  assign load_ok = (32'(in_component) < gmmdp_pkg::NUM_COMPONENTS)
                && (32'(in_position) < gmmdp_pkg::NUM_DIMS);

  logic [15:0] mean_q;
  logic [15:0] var_q;
  logic [15:0] sample_q;
  logic [31:0] score_q;
  logic        score_we;
  logic [31:0] score_wd;

  always_ff @(posedge clk) begin
    if (s_acc && s_tuser == gmmdp_pkg::KIND_LOAD && load_ok) begin
      mean_mem[wr_addr] <= in_mean;
      var_mem[wr_addr]  <= in_variance;
    end
    mean_q <= mean_mem[rd_addr];
    var_q  <= var_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (s_acc && s_tuser != gmmdp_pkg::KIND_LOAD
        && 32'(in_position) < gmmdp_pkg::NUM_DIMS) begin
      sample_mem[in_position[DW-1:0]] <= in_sample;
    end
    sample_q <= sample_mem[dim_idx];
  end

  always_ff @(posedge clk) begin
    if (score_we) score_mem[comp_idx] <= score_wd;
    score_q <= score_mem[comp_idx];
  end

  // Element counter of the current sample.
  logic [6:0] element_count;
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else if (s_acc && s_tuser != gmmdp_pkg::KIND_LOAD) begin
      if (s_tlast) element_count <= '0;
      else if (element_count != 7'd127) element_count <= element_count + 1'b1;
    end
  end

  // Distance datapath.
  logic signed [16:0] diff;
  logic [16:0]        w_val;
  logic [33:0]        sq_prod;
  logic [16:0]        w_reg;
  assign diff  = $signed({sample_q[15], sample_q}) - $signed({mean_q[15], mean_q});
  assign w_val = {1'b0, var_q} + 17'd1;

  logic                 div_start;
  gmmdp_pkg::div_resp_t div_resp;
  assign div_start = (state == ST_DIV);

  gmmdp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sq_prod[32:0], 8'd0}),
    .divisor  (w_reg),
    .resp     (div_resp)
  );

  logic [46:0]        sq_sum;
  logic signed [31:0] lg_sum;
  logic signed [31:0] ln_w;
  assign ln_w = gmmdp_pkg::ln_q({4'd0, w_reg}, 5'd8);

  // Score: -(total/2) truncated toward zero, saturated to 32 bits.
  logic signed [48:0] total;
  logic signed [48:0] half;
  logic signed [48:0] neg_half;
  logic signed [31:0] score_sat;
  always_comb begin
    total    = $signed({2'b00, sq_sum})
             + $signed(49'(kd_run) * 49'(gmmdp_pkg::LN2PI_Q16))
             + 49'(lg_sum);
    half     = (total + 49'(total[48])) >>> 1;
    neg_half = -half;
    if (neg_half > 49'sd2147483647) score_sat = 32'sh7fffffff;
    else if (neg_half < -49'sd2147483648) score_sat = 32'sh80000000;
    else score_sat = neg_half[31:0];
  end
  assign score_we = (state == ST_SCORE);
  assign score_wd = score_sat;

  logic signed [31:0] max_score;

  // Exponential datapath.
  logic [17:0]        lsum;
  logic signed [33:0] z_val;
  logic [33:0]        a_val;
  logic [50:0]        t_prod;
  logic [34:0]        t_val;
  logic [16:0]        e_val;
  logic [20:0]        ssum;
  logic signed [31:0] ln_s;
  always_comb begin
    z_val = 34'($signed(score_q)) - 34'(max_score) - $signed({16'd0, lsum});
    a_val = -z_val;
    t_val = t_prod[50:16];
    if (t_val[34:16] > 19'd16) e_val = '0;
    else e_val = gmmdp_pkg::exp_tab(t_val[15:12]) >> t_val[20:16];
    ln_s = gmmdp_pkg::ln_q((ssum == '0) ? 21'd1 : ssum, 5'd16);
  end

  logic [15:0] post_val;

  // A posterior word enters the output register when it is empty or draining.
  logic emit_fire;
  assign emit_fire = (state == ST_EMIT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      max_score <= 32'sh80000000;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_acc && s_tuser != gmmdp_pkg::KIND_LOAD && s_tlast) begin
            kc_run     <= kc_clamp;
            kd_run     <= kd_clamp;
            comp_idx   <= '0;
            dim_idx    <= '0;
            sq_sum     <= '0;
            lg_sum     <= '0;
            lsum       <= '0;
            ssum       <= '0;
            post_phase <= 1'b0;
            max_score  <= 32'sh80000000;
            state      <= ST_RD;
          end
        end
        ST_RD: state <= ST_MUL;
        ST_MUL: begin
          sq_prod <= $unsigned(34'(diff) * 34'(diff));
          w_reg   <= w_val;
          state   <= ST_DIV;
        end
        ST_DIV: state <= ST_WAIT;
        ST_WAIT: begin
          if (div_resp.done) begin
            sq_sum <= sq_sum + 47'(div_resp.quotient);
            lg_sum <= lg_sum + ln_w;
            if ((DW+1)'(dim_idx) == kd_run - 1'b1) begin
              state <= ST_SCORE;
            end else begin
              dim_idx <= dim_idx + 1'b1;
              state   <= ST_RD;
            end
          end
        end
        ST_SCORE: begin
          if (score_sat > max_score) max_score <= score_sat;
          sq_sum  <= '0;
          lg_sum  <= '0;
          dim_idx <= '0;
          if ((CW+1)'(comp_idx) == kc_run - 1'b1) begin
            comp_idx <= '0;
            state    <= ST_ERD;
          end else begin
            comp_idx <= comp_idx + 1'b1;
            state    <= ST_RD;
          end
        end
        ST_ERD: state <= ST_EMUL;
        ST_EMUL: begin
          t_prod <= 51'(a_val) * 51'(INV_MUL);
          state  <= ST_ELUT;
        end
        ST_ELUT: begin
          if (post_phase) begin
            post_val <= (e_val > 17'd65535) ? 16'hffff : e_val[15:0];
            state    <= ST_EMIT;
          end else begin
            ssum <= ssum + 21'(e_val);
            if ((CW+1)'(comp_idx) == kc_run - 1'b1) begin
              comp_idx <= '0;
              state    <= ST_LN;
            end else begin
              comp_idx <= comp_idx + 1'b1;
              state    <= ST_ERD;
            end
          end
        end
        ST_LN: begin
          lsum       <= (ln_s < 0) ? '0 : ln_s[17:0];
          post_phase <= 1'b1;
          state      <= ST_ERD;
        end
        ST_EMIT: begin
          if (emit_fire) begin
            m_tdata  <= {4'd0, post_val, 4'(comp_idx)};
            m_tlast  <= ((CW+1)'(comp_idx) == kc_run - 1'b1);
            if ((CW+1)'(comp_idx) == kc_run - 1'b1) begin
              state <= ST_IDLE;
            end else begin
              comp_idx <= comp_idx + 1'b1;
              state    <= ST_ERD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A finished sample always restarts the element count.
  `GMMDP_ASSERT_NEXT(a_count_clear, s_acc && s_tuser != gmmdp_pkg::KIND_LOAD && s_tlast, element_count == '0, "element count not cleared after last element")
  // The divider never answers in the cycle right after a start.
  `GMMDP_ASSERT_NEXT(a_div_latency, div_start, !div_resp.done, "divider finished too early")
  // Posteriors are only produced for components inside the run.
  `GMMDP_ASSERT_NOW(a_emit_range, state == ST_EMIT, (CW+1)'(comp_idx) < kc_run, "component index beyond run")

endmodule

// ----- tb/gmm_posterior_checker.sv -----
// Checker for the diagonal Gaussian mixture posterior block: snoops the word,
// result and register channels, predicts posteriors and compares them.
// Depends on gmmdp_pkg for the store sizes and codes.
module gmm_posterior_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        s_tuser,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LN2_FIX = 45426;
  localparam longint LN2PI_FIX = 120447;
  localparam longint INV_LN2_FIX = 94548;

  typedef struct packed {
    logic [3:0]  comp;
    logic [15:0] post;
    logic        last;
  } posterior_t;

  longint ln_frac[16] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783,
                          26573, 29248, 31818, 34292, 36675, 38975, 41196, 43345};
  longint exp_frac[16] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                           46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219};

  logic signed [15:0] mean_mem [gmmdp_pkg::NUM_COMPONENTS*gmmdp_pkg::NUM_DIMS];
  logic [15:0]        var_mem  [gmmdp_pkg::NUM_COMPONENTS*gmmdp_pkg::NUM_DIMS];
  logic signed [15:0] feature  [gmmdp_pkg::NUM_DIMS];
  int                 comps_reg;
  int                 dims_reg;
  posterior_t         posterior_q[$];

  // Natural log of x / 2^fb in Q16.16, octave plus a four-bit table fraction.
  function automatic longint log_fix(longint x, int fb);
    int     p;
    longint k;
    p = 0;
    for (int i = 0; i < 63; i++) begin
      if (x[i]) p = i;
    end
    if (p >= 4) k = (x >> (p - 4)) & 15;
    else k = (x << (4 - p)) & 15;
    return longint'(p - fb) * LN2_FIX + ln_frac[k];
  endfunction

  // Exponential of a non-positive Q16.16 value, Q1.16 result.
  function automatic longint exp_fix(longint z);
    longint a, t, n;
    if (z > 0) z = 0;
    a = -z;
    if (a > (longint'(1) << 40)) return 0;
    t = (a * INV_LN2_FIX) >> 16;
    n = t >> 16;
    if (n > 16) return 0;
    return exp_frac[(t >> 12) & 15] >> n;
  endfunction

  task automatic score_sample();
    int         kc, kd;
    longint     sq, lg, total, s, diff, w, best, ssum, lsum, e;
    longint     score [16];
    posterior_t r;
    kc = comps_reg;
    if (kc > 16) kc = 16;
    if (kc < 1) kc = 1;
    kd = dims_reg;
    if (kd > gmmdp_pkg::NUM_DIMS) kd = gmmdp_pkg::NUM_DIMS;
    if (kd < 1) kd = 1;
    best = -(longint'(1) << 31);
    for (int c = 0; c < kc; c++) begin
      sq = 0;
      lg = 0;
      for (int d = 0; d < kd; d++) begin
        diff = longint'(feature[d])
             - longint'(mean_mem[c*gmmdp_pkg::NUM_DIMS+d]);
        w = longint'(var_mem[c*gmmdp_pkg::NUM_DIMS+d]) + 1;
        sq += ((diff * diff) << 8) / w;
        lg += log_fix(w, 8);
      end
      total = sq + longint'(kd) * LN2PI_FIX + lg;
      s = -(total / 2);
      if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
      if (s < -(longint'(1) << 31)) s = -(longint'(1) << 31);
      score[c] = s;
      if (s > best) best = s;
    end
    ssum = 0;
    for (int c = 0; c < kc; c++) ssum += exp_fix(score[c] - best);
    if (ssum < 1) ssum = 1;
    lsum = log_fix(ssum, 16);
    if (lsum < 0) lsum = 0;
    for (int c = 0; c < kc; c++) begin
      e = exp_fix(score[c] - best - lsum);
      if (e > 65535) e = 65535;
      r.comp = 4'(c);
      r.post = 16'(e);
      r.last = (c + 1 == kc);
      posterior_q.push_back(r);
    end
  endtask

  task automatic check_result();
    posterior_t want;
    if (posterior_q.size() == 0) begin
      $error("posterior word with no expectation pending: %h", m_tdata);
      fail_count++;
    end else begin
      want = posterior_q.pop_front();
      if (m_tdata[3:0] != want.comp) begin
        $error("result_component expected %0d actual %0d", want.comp, m_tdata[3:0]);
        fail_count++;
      end
      if (m_tdata[19:4] != want.post) begin
        $error("posterior expected %0d actual %0d", want.post, m_tdata[19:4]);
        fail_count++;
      end
      if (m_tlast != want.last) begin
        $error("last_result expected %0b actual %0b", want.last, m_tlast);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      comps_reg = 16;
      dims_reg = 64;
      fail_count = 0;
      posterior_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gmmdp_pkg::CFG_COMPONENTS) comps_reg = cfg_data & 7'h1F;
        else if (cfg_index == gmmdp_pkg::CFG_DIMS) dims_reg = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == gmmdp_pkg::KIND_LOAD) begin
          mean_mem[s_tdata[3:0]*gmmdp_pkg::NUM_DIMS + s_tdata[9:4]] = s_tdata[25:10];
          var_mem[s_tdata[3:0]*gmmdp_pkg::NUM_DIMS + s_tdata[9:4]] = s_tdata[41:26];
        end else begin
          feature[s_tdata[9:4]] = s_tdata[57:42];
          if (s_tlast) score_sample();
        end
      end
      if (m_tvalid && m_tready) check_result();
    end
    pending = posterior_q.size();
  end

endmodule

// ----- tb/tb_gmm_diagonal_posterior_top.sv -----
// Testbench top for the diagonal Gaussian mixture posterior block: drives
// model loads, samples and register writes, and gives the verdict.
// Depends on gmm_diagonal_posterior_top, gmm_posterior_checker and gmmdp_pkg.
module tb_gmm_diagonal_posterior_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The slowest sample here is one component over 64 dims, and the largest the
  // block allows is 16 components over 64 dims; the watchdog allows more quiet
  // time than either needs with no word moving.
  localparam int STALL_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_data = '0;
  int          fail_count;
  int          pending;
  int          quiet_cycles = 0;
  // While set, neither side inserts idle cycles or stalls.
  bit          no_idling = 1'b0;

  always #5 clk = ~clk;

  gmm_diagonal_posterior_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  gmm_posterior_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  // The receiver stalls at random about ten percent of the time, except in calm stretches.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= no_idling || ($urandom_range(99) >= 10);
  end

  // The run is stuck if no word moves on any channel for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sends one word; returns right at the edge where it is accepted. Gaps go in
  // front of the word, so valid is lowered and raised on different edges.
  task automatic send_word(logic kind, logic [3:0] comp, logic [5:0] pos,
                           logic [15:0] mean, logic [15:0] vari, logic [15:0] feat,
                           logic last);
    bit ok;
    if (!no_idling && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tlast  <= last;
    s_tdata  <= {6'd0, feat, vari, mean, pos, comp};
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic load_entry(logic [3:0] comp, logic [5:0] pos, logic [15:0] mean,
                            logic [15:0] vari);
    send_word(gmmdp_pkg::KIND_LOAD, comp, pos, mean, vari, 16'($urandom), 1'b0);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    bit ok;
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for every posterior, then lets the block finish any trailing work.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Variances drawn mostly at random, with the zero and full-scale extremes.
  function automatic logic [15:0] pick_variance();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(2048));
      default: return 16'($urandom);
    endcase
  endfunction

  // One sample over dims elements in shuffled order. A broken sample may add
  // a stray element anywhere or stop early; the buffer is fully written by
  // then, so every read still hits a written entry.
  task automatic run_sample(int dims, bit broken);
    int order [64];
    int j, tmp, count;
    logic [15:0] val;
    for (int i = 0; i < 64; i++) order[i] = i;
    for (int i = dims - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    count = dims;
    if (broken && dims > 1 && $urandom_range(1)) count = $urandom_range(dims - 1, 1);
    for (int i = 0; i < count; i++) begin
      if (broken && $urandom_range(3) == 0)
        send_word(gmmdp_pkg::KIND_ELEMENT, 4'($urandom), 6'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 1'b0);
      val = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1024));
      send_word(gmmdp_pkg::KIND_ELEMENT, 4'($urandom), 6'(order[i]), 16'($urandom),
                16'($urandom), val, i == count - 1);
    end
  endtask

  // Register settings per phase, raw as written, extremes and beyond-range
  // values among them; the block clamps those. Every setting stays inside the
  // loaded part of the model.
  int phase_comps [5] = '{0, 31, 3, 16, 2};
  int phase_dims  [5] = '{0, 2, 1, 1, 2};

  initial begin
    int kc, kd;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every component gets dimensions zero and one, and component zero gets all
    // 64, so no later sample reads an unwritten entry. Dimension zero carries
    // the mean extremes and dimension one the variance extremes.
    for (int c = 0; c < 16; c++) begin
      for (int p = 0; p < 2; p++) begin
        load_entry(4'(c), 6'(p),
                   (p == 0) ? ((c % 2) ? 16'h7FFF : 16'h8000) : 16'($urandom),
                   (p == 1) ? ((c % 2) ? 16'hFFFF : 16'h0000) : pick_variance());
      end
    end
    for (int p = 2; p < 64; p++) load_entry(4'd0, 6'(p), 16'($urandom), pick_variance());

    // Directed sample on one component over every position, with a dimension
    // count beyond range and feature extremes, sent without any idling.
    write_reg(gmmdp_pkg::CFG_COMPONENTS, 7'd1);
    write_reg(gmmdp_pkg::CFG_DIMS, 7'd127);
    no_idling = 1'b1;
    for (int p = 0; p < 64; p++) begin
      send_word(gmmdp_pkg::KIND_ELEMENT, 4'd0, 6'(p), 16'd0, 16'd0,
                (p == 0) ? 16'h7FFF : (p == 1) ? 16'h8000 : 16'($urandom),
                p == 63);
    end
    settle();
    no_idling = 1'b0;

    // Equal components: the same model at dimension zero for four of them,
    // so the mass is spread evenly.
    write_reg(gmmdp_pkg::CFG_COMPONENTS, 7'd4);
    write_reg(gmmdp_pkg::CFG_DIMS, 7'd1);
    for (int c = 0; c < 4; c++) load_entry(4'(c), 6'd0, 16'h0100, 16'h0400);
    send_word(gmmdp_pkg::KIND_ELEMENT, 4'd0, 6'd0, 16'd0, 16'd0, 16'h0080, 1'b1);
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(gmmdp_pkg::CFG_COMPONENTS, 7'(phase_comps[ph]));
      write_reg(gmmdp_pkg::CFG_DIMS, 7'(phase_dims[ph]));
      kc = phase_comps[ph] & 31;
      kc = (kc < 1) ? 1 : (kc > 16) ? 16 : kc;
      kd = phase_dims[ph];
      kd = (kd < 1) ? 1 : (kd > 64) ? 64 : kd;
      for (int n = 0; n < 2; n++) begin
        // Now and then a fresh model entry inside the active area, with a mean
        // near zero at times so the posteriors spread.
        repeat ($urandom_range(1)) begin
          load_entry(4'($urandom_range(kc - 1)), 6'($urandom_range(kd - 1)),
                     $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(512)),
                     pick_variance());
        end
        run_sample(kd, $urandom_range(3) == 0);
      end
      settle();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
